@@ sv/mru_pkg.sv @@
// Shared types and codes for the MRU list with pinned entries.
package mru_pkg;

   typedef enum logic [1:0] {
      OP_TOUCH = 2'd0,
      OP_PIN   = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_RANGE     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } ctrl_type;

endpackage

@@ sv/mru_ctrl.sv @@
// Controller: capture an item, run one update step, answer.
module mru_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output mru_pkg::ctrl_type ctrl
);
   import mru_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start) state_in = S_EXEC;
         S_EXEC: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctrl.load = 1'b0;
      ctrl.exec = 1'b0;
      busy      = 1'b0;
      case (state_ff)
         S_IDLE: ctrl.load = start;
         S_EXEC: begin
            ctrl.exec = 1'b1;
            busy      = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end
endmodule

@@ sv/mru_dp.sv @@
// Datapath: register row of entries, parallel compare, victim pick, shift.
module mru_dp #(
   parameter int CAPACITY = 32,
   parameter int KEY_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  mru_pkg::ctrl_type ctrl,
   input  logic [1:0]        req_opcode,
   input  logic [31:0]       req_key,
   input  logic [31:0]       req_name_tag,
   input  logic [63:0]       req_opened_time,
   input  logic [63:0]       req_entry_version,
   input  logic              req_pin_value,
   input  logic [4:0]        req_position,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [31:0]       rsp_out_key,
   output logic [31:0]       rsp_out_name_tag,
   output logic [63:0]       rsp_out_opened_time,
   output logic [63:0]       rsp_out_entry_version,
   output logic              rsp_out_pinned,
   output logic [5:0]        rsp_entry_total,
   output logic [63:0]       rsp_change_count
);
   import mru_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;

   logic [KW-1:0] key_ff [CAPACITY];
   logic [31:0]   tag_ff [CAPACITY];
   logic [63:0]   time_ff[CAPACITY];
   logic [63:0]   ver_ff [CAPACITY];
   logic          pin_ff [CAPACITY];
   logic [CW-1:0] fill_ff;
   logic [63:0]   chg_ff;

   // captured item
   logic [1:0]    op_ff;
   logic [KW-1:0] rkey_ff;
   logic [31:0]   rtag_ff;
   logic [63:0]   rtime_ff, rver_ff;
   logic          rpin_ff;
   logic [4:0]    rpos_ff;

   logic          rv_ff;
   logic [1:0]    rst_ff;
   logic [31:0]   rk_ff, rt_ff;
   logic [63:0]   rtm_ff, rvr_ff;
   logic          rp_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         op_ff    <= req_opcode;
         rkey_ff  <= req_key[KW-1:0];
         rtag_ff  <= req_name_tag;
         rtime_ff <= req_opened_time;
         rver_ff  <= req_entry_version;
         rpin_ff  <= req_pin_value;
         rpos_ff  <= req_position;
      end
   end

   // parallel key compare, first match wins
   logic [CAPACITY-1:0] hit;
   logic                found;
   logic [IW-1:0]       hit_pos;
   logic                full;
   logic [IW-1:0]       victim;
   logic [IW-1:0]       gap;
   logic                drop;
   logic                keep_pin;

   always_comb begin
      found   = 1'b0;
      hit_pos = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         hit[i] = (i < fill_ff) && (key_ff[i] == rkey_ff);
         if (hit[i]) begin
            found   = 1'b1;
            hit_pos = IW'(i);
         end
      end
      full   = (fill_ff == CW'(CAPACITY));
      // last unpinned entry, else position 0
      victim = '0;
      for (int i = 1; i < CAPACITY; i++)
         if (!pin_ff[i]) victim = IW'(i);
      gap      = found ? hit_pos : victim;
      drop     = found || full;
      keep_pin = found ? pin_ff[hit_pos] : 1'b0;
   end

   logic do_touch, do_pin;
   logic [4:0]    rd_idx;
   logic [IW-1:0] rd_addr;
   logic          rd_ok;
   assign do_touch = ctrl.exec && (op_ff == OP_TOUCH);
   assign do_pin   = ctrl.exec && (op_ff == OP_PIN) && found;
   assign rd_idx   = rpos_ff;
   assign rd_addr  = IW'(rd_idx);
   assign rd_ok    = 7'(rd_idx) < 7'(fill_ff);

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (do_touch) begin
            if (i == 0) begin
               key_ff[0]  <= rkey_ff;
               tag_ff[0]  <= rtag_ff;
               time_ff[0] <= rtime_ff;
               ver_ff[0]  <= rver_ff;
               pin_ff[0]  <= keep_pin;
            end else if (!drop || i <= int'(gap)) begin
               // advance entries below the gap (all entries if none is dropped) by one place
               key_ff[i]  <= key_ff[i-1];
               tag_ff[i]  <= tag_ff[i-1];
               time_ff[i] <= time_ff[i-1];
               ver_ff[i]  <= ver_ff[i-1];
               pin_ff[i]  <= pin_ff[i-1];
            end
         end else if (do_pin && hit_pos == IW'(i)) begin
            pin_ff[i] <= rpin_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         chg_ff  <= '0;
         rv_ff   <= 1'b0;
      end else begin
         rv_ff <= ctrl.exec;
         if (do_touch && !drop) fill_ff <= fill_ff + CW'(1);
         if (do_touch || do_pin) chg_ff <= chg_ff + 64'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         rst_ff <= ST_OK;
         rk_ff  <= '0;
         rt_ff  <= '0;
         rtm_ff <= '0;
         rvr_ff <= '0;
         rp_ff  <= 1'b0;
         if (op_ff == OP_PIN && !found) rst_ff <= ST_NOT_FOUND;
         if (op_ff == OP_READ) begin
            if (rd_ok) begin
               rk_ff  <= 32'(key_ff[rd_addr]);
               rt_ff  <= tag_ff[rd_addr];
               rtm_ff <= time_ff[rd_addr];
               rvr_ff <= ver_ff[rd_addr];
               rp_ff  <= pin_ff[rd_addr];
            end else begin
               rst_ff <= ST_RANGE;
            end
         end
      end
   end

   assign rsp_valid             = rv_ff;
   assign rsp_status            = rst_ff;
   assign rsp_out_key           = rk_ff;
   assign rsp_out_name_tag      = rt_ff;
   assign rsp_out_opened_time   = rtm_ff;
   assign rsp_out_entry_version = rvr_ff;
   assign rsp_out_pinned        = rp_ff;
   assign rsp_entry_total       = 6'(fill_ff);
   assign rsp_change_count      = chg_ff;
endmodule

@@ sv/mru_list_with_pinned_entries.sv @@
// Top level: MRU list of pinned/unpinned entries with command interface.
// Result path: start is captured in S_IDLE, the update runs in S_EXEC, then rsp_valid is registered.
// Sequencing: a new item is taken only in S_IDLE, after the capture/update pair of the last one.
// Each item updates the whole register row in one step: parallel compare and shift.
// Reset: synchronous, empties the list and clears the revision counter.
// Results are never held; rsp_valid lasts exactly one cycle.
module mru_list_with_pinned_entries #(
   parameter int CAPACITY = 32,
   parameter int KEY_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_key,
   input  logic [31:0] req_name_tag,
   input  logic [63:0] req_opened_time,
   input  logic [63:0] req_entry_version,
   input  logic        req_pin_value,
   input  logic [4:0]  req_position,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_out_key,
   output logic [31:0] rsp_out_name_tag,
   output logic [63:0] rsp_out_opened_time,
   output logic [63:0] rsp_out_entry_version,
   output logic        rsp_out_pinned,
   output logic [5:0]  rsp_entry_total,
   output logic [63:0] rsp_change_count
);
   import mru_pkg::*;

   ctrl_type ctrl;

   mru_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .ctrl(ctrl)
   );

   mru_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl),
      .req_opcode(req_opcode), .req_key(req_key), .req_name_tag(req_name_tag),
      .req_opened_time(req_opened_time), .req_entry_version(req_entry_version),
      .req_pin_value(req_pin_value), .req_position(req_position),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_out_key(rsp_out_key),
      .rsp_out_name_tag(rsp_out_name_tag), .rsp_out_opened_time(rsp_out_opened_time),
      .rsp_out_entry_version(rsp_out_entry_version), .rsp_out_pinned(rsp_out_pinned),
      .rsp_entry_total(rsp_entry_total), .rsp_change_count(rsp_change_count)
   );

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid) else $error("missing result");
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      7'(rsp_entry_total) <= 7'(CAPACITY)) else $error("entry total too large");
   a_busy_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without work");
endmodule
